// ===== hdl/ctpd_pkg.sv =====
// Package for the Cartesian-to-polar converter: word types, fixed-point
// widths, gain and angle constants, and the arctangent table of the CORDIC.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctpd_pkg;

	localparam int DATA_WIDTH = 24;
	localparam int ITERATIONS = 24;
	localparam int GUARD      = 8;

	// Working width of the rotation registers: input, guard bits, and headroom
	// for the CORDIC gain and the diagonal of the input square.
	localparam int XW  = DATA_WIDTH + GUARD + 4;
	// The final x is never negative and stays below 2^(XW-2).
	localparam int UXW = XW - 2;

	localparam int ZW = 32;

	// Gain 0.6072529350088813 in Q32, split into two 16-bit halves.
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
	localparam logic [15:0] GAIN_HI  = GAIN_Q32[31:16];
	localparam logic [15:0] GAIN_LO  = GAIN_Q32[15:0];

	localparam int PRODW = UXW + 16;
	localparam int SUMW  = PRODW + 1;
	localparam int AMPFW = SUMW - (16 + GUARD);

	localparam logic [ZW-1:0] Z_HALF_TURN = 32'h8000_0000;

	// Phase scaling: degrees * 65536 = binary angle * 45 / 2^13.
	localparam int PHASE_W     = 25;
	localparam int PHASE_SHIFT = 13;
	localparam int PHMW        = ZW + 6;
	localparam logic [5:0]         PHASE_MULT  = 6'd45;
	localparam logic [PHMW-1:0]    PHASE_ROUND = PHMW'(4096);
	localparam logic [PHASE_W-1:0] TURN_360    = 25'd23592960;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] cos_component;
		logic signed [DATA_WIDTH-1:0] sin_component;
	} cart_word_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] amplitude;
		logic [PHASE_W-1:0]    phase_degrees;
	} polar_word_t;

	// round(atan(2^-i) * 2^32 / (2*pi)); zero past the end of the table.
	function automatic logic [ZW-1:0] atan_entry(input int i);
		logic [ZW-1:0] r;
		case (i)
			0:       r = 32'h2000_0000;
			1:       r = 32'h12E4_051E;
			2:       r = 32'h09FB_385B;
			3:       r = 32'h0511_11D4;
			4:       r = 32'h028B_0D43;
			5:       r = 32'h0145_D7E1;
			6:       r = 32'h00A2_F61E;
			7:       r = 32'h0051_7C55;
			8:       r = 32'h0028_BE53;
			9:       r = 32'h0014_5F2F;
			10:      r = 32'h000A_2F98;
			11:      r = 32'h0005_17CC;
			12:      r = 32'h0002_8BE6;
			13:      r = 32'h0001_45F3;
			14:      r = 32'h0000_A2FA;
			15:      r = 32'h0000_517D;
			16:      r = 32'h0000_28BE;
			17:      r = 32'h0000_145F;
			18:      r = 32'h0000_0A30;
			19:      r = 32'h0000_0518;
			20:      r = 32'h0000_028C;
			21:      r = 32'h0000_0146;
			22:      r = 32'h0000_00A3;
			23:      r = 32'h0000_0051;
			24:      r = 32'h0000_0029;
			25:      r = 32'h0000_0014;
			26:      r = 32'h0000_000A;
			27:      r = 32'h0000_0005;
			28:      r = 32'h0000_0003;
			29:      r = 32'h0000_0001;
			30:      r = 32'h0000_0001;
			default: r = 32'h0000_0000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cartesian_to_polar_degrees.sv =====
// Cartesian-to-polar converter in degrees, built as a pipelined CORDIC.
// Depends on ctpd_pkg for word types, widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

// Takes a word of signed cosine and sine components and returns the rounded,
// gain-compensated magnitude and the phase atan2(sin, cos) in degrees times
// 65536, in the range (0, 360]; a phase that rounds to zero, and the zero
// vector, read as 360 degrees. One word enters per clock while cs_stall is
// low. The pipeline has one stage for the half-plane fold, one stage per
// CORDIC micro-rotation, one for the gain and phase multiplies and one output
// register. Each stage holds only while the stage after it is full and held,
// so words keep moving into empty slots while a result waits.
module cartesian_to_polar_degrees
	import ctpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cs_valid,
	output logic             cs_stall,
	input  wire cart_word_t  cs_word,
	output logic             pol_valid,
	input  wire logic        pol_stall,
	output polar_word_t      pol_word
);

	// Rotation stages: index 0 is the fold stage, index i+1 follows rotation i.
	logic                 vld_s  [ITERATIONS+1];
	logic                 zero_s [ITERATIONS+1];
	logic signed [XW-1:0] x_s    [ITERATIONS+1];
	logic signed [XW-1:0] y_s    [ITERATIONS+1];
	logic [ZW-1:0]        z_s    [ITERATIONS+1];
	logic                 en_s   [ITERATIONS+1];

	logic             vld_sm, zero_sm, en_sm;
	logic [PRODW-1:0] hi_sm, lo_sm;
	logic [PHMW-1:0]  ph_sm;

	logic en_so;

	// Stage enables: a stage may load when it is empty or its successor loads.
	always_comb begin
		en_so = !pol_valid || !pol_stall;
		en_sm = !vld_sm || en_so;
		en_s[ITERATIONS] = !vld_s[ITERATIONS] || en_sm;
		for (int k = ITERATIONS - 1; k >= 0; k--) begin
			en_s[k] = !vld_s[k] || en_s[k+1];
		end
		cs_stall = !en_s[0];
	end

	// Fold stage: a vector in the left half plane is turned by 180 degrees.
	logic signed [XW-1:0] c_ext, s_ext;
	always_comb begin
		c_ext = XW'(cs_word.cos_component) <<< GUARD;
		s_ext = XW'(cs_word.sin_component) <<< GUARD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en_s[0]) begin
			vld_s[0] <= cs_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			zero_s[0] <= (cs_word.cos_component == '0) && (cs_word.sin_component == '0);
			if (c_ext[XW-1]) begin
				x_s[0] <= -c_ext;
				y_s[0] <= -s_ext;
				z_s[0] <= Z_HALF_TURN;
			end else begin
				x_s[0] <= c_ext;
				y_s[0] <= s_ext;
				z_s[0] <= '0;
			end
		end
	end

	// One micro-rotation per stage; the arithmetic shift rounds toward minus
	// infinity, as the fixed-point format requires.
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
		localparam logic [ZW-1:0] ATAN_I = atan_entry(i);
		logic signed [XW-1:0] xsh, ysh;

		assign xsh = x_s[i] >>> i;
		assign ysh = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en_s[i+1]) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[i+1]) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] + ysh;
					y_s[i+1] <= y_s[i] - xsh;
					z_s[i+1] <= z_s[i] + ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] - ysh;
					y_s[i+1] <= y_s[i] + xsh;
					z_s[i+1] <= z_s[i] - ATAN_I;
				end
			end
		end
	end

	// Multiply stage: gain halves on the magnitude, degree scaling on the angle.
	logic [UXW-1:0] ux;
	assign ux = UXW'(unsigned'(x_s[ITERATIONS]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (en_sm) begin
			vld_sm <= vld_s[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sm) begin
			zero_sm <= zero_s[ITERATIONS];
			hi_sm   <= PRODW'(ux) * PRODW'(GAIN_HI);
			lo_sm   <= PRODW'(ux) * PRODW'(GAIN_LO);
			ph_sm   <= PHMW'(z_s[ITERATIONS]) * PHMW'(PHASE_MULT) + PHASE_ROUND;
		end
	end

	// Output stage: combine partial products, round, saturate, wrap the phase.
	logic [SUMW-1:0]          prod;
	logic [SUMW-1:0]          prod_rnd;
	logic [AMPFW-1:0]         amp_full;
	logic [DATA_WIDTH-1:0]    amp;
	logic [PHASE_W-1:0]       ph;

	always_comb begin
		prod     = SUMW'(hi_sm) + SUMW'(lo_sm >> 16);
		prod_rnd = prod + (SUMW'(1) << (16 + GUARD - 1));
		amp_full = prod_rnd[SUMW-1:16+GUARD];
		if (amp_full > AMPFW'({DATA_WIDTH{1'b1}})) begin
			amp = '1;
		end else begin
			amp = amp_full[DATA_WIDTH-1:0];
		end
		ph = ph_sm[PHASE_SHIFT+PHASE_W-1:PHASE_SHIFT];
		if (zero_sm || ph == '0) begin
			ph = TURN_360;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_valid <= 1'b0;
		end else if (en_so) begin
			pol_valid <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (en_so) begin
			pol_word.amplitude     <= zero_sm ? '0 : amp;
			pol_word.phase_degrees <= ph;
		end
	end

endmodule

`default_nettype wire

// ===== sim/cartesian_to_polar_degrees_tb.sv =====
// Self-checking testbench for cartesian_to_polar_degrees: drives coefficient words,
// predicts magnitude and phase in degrees with its own CORDIC, and checks every result.
// Depends on ctpd_pkg and the cartesian_to_polar_degrees RTL.
`timescale 1ns / 1ps

module cartesian_to_polar_degrees_tb;
	import ctpd_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 15;
	localparam int MAX_REPORTS  = 10;

	localparam logic signed [DATA_WIDTH-1:0] COMP_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] COMP_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [63:0] GAIN_UPPER = 64'(GAIN_Q32) >> 16;
	localparam logic [63:0] GAIN_LOWER = 64'(GAIN_Q32) & 64'hFFFF;
	localparam logic [63:0] AMP_MAX    = (64'd1 << DATA_WIDTH) - 64'd1;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cs_valid  = 1'b0;
	logic        cs_stall;
	cart_word_t  cs_word   = '0;
	logic        pol_valid;
	logic        pol_stall = 1'b0;
	polar_word_t pol_word;

	// Sender and receiver idle only while these are set.
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	polar_word_t pending_polar[$];
	int          mismatches  = 0;
	int          quiet_cycles = 0;

	// Binary-angle arctangent of 2^-i, 2^32 per turn.
	logic [31:0] atan_turn [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	cartesian_to_polar_degrees u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cs_valid  (cs_valid),
		.cs_stall  (cs_stall),
		.cs_word   (cs_word),
		.pol_valid (pol_valid),
		.pol_stall (pol_stall),
		.pol_word  (pol_word)
	);

	always #10 clk = ~clk;

	function automatic polar_word_t polar_of(input cart_word_t w);
		longint      c, s, x, y, xs, ys;
		logic [31:0] turn;
		logic [63:0] mag, prod, amp, ph;
		polar_word_t r;
		c = longint'(w.cos_component);
		s = longint'(w.sin_component);
		if (c == 0 && s == 0) begin
			r.amplitude     = '0;
			r.phase_degrees = TURN_360;
			return r;
		end
		x    = c * 256;
		y    = s * 256;
		turn = '0;
		// Left half plane: turn the vector by half a turn first.
		if (x < 0) begin
			x    = -x;
			y    = -y;
			turn = Z_HALF_TURN;
		end
		for (int i = 0; i < ITERATIONS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x    = x + ys;
				y    = y - xs;
				turn = turn + atan_turn[i];
			end else begin
				x    = x - ys;
				y    = y + xs;
				turn = turn - atan_turn[i];
			end
		end
		mag  = x;
		prod = mag * GAIN_UPPER + ((mag * GAIN_LOWER) >> 16);
		amp  = (prod + (64'd1 << (16 + GUARD - 1))) >> (16 + GUARD);
		if (amp > AMP_MAX)
			amp = AMP_MAX;
		ph = ({32'd0, turn} * 64'd45 + 64'd4096) >> 13;
		// A phase that rounds to zero reads as a full turn.
		if (ph == 0)
			ph = 64'(TURN_360);
		r.amplitude     = amp[DATA_WIDTH-1:0];
		r.phase_degrees = ph[PHASE_W-1:0];
		return r;
	endfunction

	// Presents one word and returns at the edge where it is taken; valid stays high
	// so that a following word with no gap is presented on the next cycle.
	task automatic send_cart(input logic signed [DATA_WIDTH-1:0] c,
			input logic signed [DATA_WIDTH-1:0] s);
		int unsigned gap;
		cart_word_t  w;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			cs_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.cos_component = c;
		w.sin_component = s;
		cs_valid <= 1'b1;
		cs_word  <= w;
		do @(posedge clk); while (cs_stall);
		pending_polar.push_back(polar_of(w));
	endtask

	task automatic hold_off_until_drained();
		cs_valid <= 1'b0;
		while (pending_polar.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_zero_and_axes();
		send_cart(0, 0);
		send_cart(1, 0);
		send_cart(-1, 0);
		send_cart(0, 1);
		send_cart(0, -1);
		send_cart(COMP_MAX, 0);
		send_cart(COMP_MIN, 0);
		send_cart(0, COMP_MAX);
		send_cart(0, COMP_MIN);
	endtask

	task automatic test_corners();
		send_cart(COMP_MAX, COMP_MAX);
		send_cart(COMP_MIN, COMP_MIN);
		send_cart(COMP_MAX, COMP_MIN);
		send_cart(COMP_MIN, COMP_MAX);
		send_cart(1, 1);
		send_cart(-1, -1);
		// Just below and just above the zero angle, either side of half a turn, and either side of three quarters of a turn.
		send_cart(COMP_MAX, -1);
		send_cart(COMP_MAX, 1);
		send_cart(COMP_MIN, 1);
		send_cart(COMP_MIN, -1);
		send_cart(-1, COMP_MIN);
		send_cart(1, COMP_MIN);
	endtask

	task automatic test_random_plane(input int count);
		for (int n = 0; n < count; n++)
			send_cart(DATA_WIDTH'($urandom()), DATA_WIDTH'($urandom()));
	endtask

	task automatic test_random_small(input int count);
		for (int n = 0; n < count; n++)
			send_cart(DATA_WIDTH'(int'($urandom_range(0, 64)) - 32),
				DATA_WIDTH'(int'($urandom_range(0, 64)) - 32));
	endtask

	task automatic test_random_near_axes(input int count);
		logic signed [DATA_WIDTH-1:0] big, tiny;
		for (int n = 0; n < count; n++) begin
			big  = DATA_WIDTH'($urandom());
			tiny = DATA_WIDTH'(int'($urandom_range(0, 16)) - 8);
			if ($urandom_range(0, 1))
				send_cart(big, tiny);
			else
				send_cart(tiny, big);
		end
	endtask

	task automatic test_back_to_back(input int count);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random_plane(count);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_and_axes();
		test_corners();
		hold_off_until_drained();

		test_random_plane(450);
		rx_idle = 1'b0;
		test_random_small(200);
		rx_idle = 1'b1;
		hold_off_until_drained();
		tx_idle = 1'b0;
		test_random_near_axes(200);
		tx_idle = 1'b1;
		test_back_to_back(150);
		test_random_plane(100);

		hold_off_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_polar.size() == 0)
			$display("cartesian_to_polar_degrees regression: pass");
		else
			$display("cartesian_to_polar_degrees regression: fail");
		$finish;
	end

	// Receiver: stalls for a random hold while rx_idle is set, then takes one word.
	initial begin
		int unsigned hold;
		forever begin
			hold = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (hold != 0) begin
				pol_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				pol_stall <= 1'b0;
			end
			do @(posedge clk); while (!pol_valid);
		end
	end

	always @(posedge clk) begin
		polar_word_t due;
		if (arst_n && pol_valid && !pol_stall) begin
			if (pending_polar.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected word amplitude %0d phase %0d", $realtime,
						pol_word.amplitude, pol_word.phase_degrees);
			end else begin
				due = pending_polar.pop_front();
				if (pol_word.amplitude !== due.amplitude ||
						pol_word.phase_degrees !== due.phase_degrees) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: amplitude exp %0d got %0d, phase exp %0d got %0d",
							$realtime, due.amplitude, pol_word.amplitude,
							due.phase_degrees, pol_word.phase_degrees);
				end
			end
		end
	end

	// Ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (cs_valid && !cs_stall) || (pol_valid && !pol_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("cartesian_to_polar_degrees regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule

// ===== files.f =====
hdl/ctpd_pkg.sv
hdl/cartesian_to_polar_degrees.sv
sim/cartesian_to_polar_degrees_tb.sv
